// ===== hdl/ust_pkg.sv =====
`default_nettype none

package ust_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_ELEM_WIDTH = 32;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 6;
  localparam int RND_W    = 16;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // request kinds on the wire
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CHOOSE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // decoded operations passed from front to back
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_CHOOSE = 3'd3;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
  localparam logic [OP_W-1:0] OP_BAD    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    logic [RND_W-1:0]   random_word;
  } req_t;

  typedef struct packed {
    logic [ITEM_W-1:0]   item;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
    logic [RND_W-1:0]   random_word;
    logic               slot_ok;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ust_stream_if.sv =====
`default_nettype none

interface ust_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ust_ram.sv =====
`default_nettype none

module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/ust_front.sv =====
`default_nettype none

module ust_front import ust_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ust_stream_if.sink  req,
  ust_stream_if.source cmd,
  input  wire logic   clear_busy
);

  // two-entry request queue
  cmd_t       q_mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec.value       = req.data.value;
    dec.slot        = req.data.slot;
    dec.random_word = req.data.random_word;
    dec.slot_ok     = (int'(req.data.slot) < CAPACITY);
    unique case (req.data.kind)
      KIND_ADD:    dec.op = OP_ADD;
      KIND_DELETE: dec.op = OP_DELETE;
      KIND_GET:    dec.op = OP_GET;
      KIND_CHOOSE: dec.op = OP_CHOOSE;
      KIND_INSERT: dec.op = OP_INSERT;
      default:     dec.op = OP_BAD;
    endcase
  end

  assign req.ready = !fill[1] && !clear_busy;
  assign push      = req.valid && req.ready;
  assign cmd.valid = (fill != 2'd0);
  assign cmd.data  = q_mem[rp];
  assign pop       = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> fill == $past(fill) - 2'd1)
    else $error("queue pop lost");
  a_empty_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> fill == 2'd0)
    else $error("request queued during clearing");

endmodule

`default_nettype wire

// ===== hdl/ust_back.sv =====
`default_nettype none

module ust_back import ust_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ust_stream_if.sink   cmd,
  ust_stream_if.source rsp,
  output logic         clear_busy
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = RND_W + CW;
  localparam int CMPW = CW + SLOT_W;

  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_MOVE  = 3'd5;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic [AW-1:0]         clr_addr;
  logic [AW-1:0]         scan_idx;
  logic [AW-1:0]         hit_idx;
  logic [ELEM_WIDTH-1:0] value_q;
  logic [PW-1:0]         prod_q;
  logic                  res_valid;
  rsp_t                  res;

  logic                  start;
  logic                  res_load;
  logic [ITEM_W-1:0]     res_item;
  logic [STATUS_W-1:0]   res_status;
  logic                  scan_hit;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [ELEM_WIDTH-1:0] rdata;

  cmd_t                  cur;
  logic [ELEM_WIDTH-1:0] cur_value;
  logic [AW-1:0]         cur_addr;
  logic                  slot_lt_cnt;

  ust_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign clear_busy  = (state == S_CLEAR);
  assign cmd.ready   = (state == S_IDLE) && !res_valid;
  assign start       = cmd.valid && cmd.ready;
  assign cur         = cmd.data;
  assign cur_value   = ELEM_WIDTH'(cur.value);
  assign cur_addr    = AW'(cur.slot);
  assign slot_lt_cnt = (CMPW'(cur.slot) < CMPW'(cnt));
  assign scan_hit    = (rdata == value_q);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = cur_value;
    raddr      = '0;
    res_load   = 1'b0;
    res_item   = '0;
    res_status = ST_MISS;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (cur.op)
            OP_ADD: begin
              res_load = 1'b1;
              if (cnt == CAP_CNT) begin
                res_status = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = AW'(cnt);
                cnt_next   = cnt + CW'(1);
                res_status = ST_OK;
              end
            end
            OP_INSERT: begin
              res_load = 1'b1;
              if (cur.slot_ok) begin
                we         = 1'b1;
                res_status = ST_OK;
                if (!slot_lt_cnt) begin
                  cnt_next = CW'(cur.slot) + CW'(1);
                end
              end
            end
            OP_GET: begin
              if (slot_lt_cnt) begin
                raddr      = cur_addr;
                state_next = S_READ;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_CHOOSE: begin
              if (cnt != '0) begin
                state_next = S_CALC;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_DELETE: begin
              if (cnt != '0) begin
                raddr      = '0;
                state_next = S_SCAN;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_CALC: begin
        raddr      = AW'(prod_q >> RND_W);
        state_next = S_READ;
      end
      S_READ: begin
        res_load   = 1'b1;
        res_status = ST_OK;
        res_item   = ITEM_W'(rdata);
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          raddr      = AW'(cnt - CW'(1));
          state_next = S_MOVE;
        end else if (CW'(scan_idx) == cnt - CW'(1)) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr = scan_idx + AW'(1);
        end
      end
      S_MOVE: begin
        we         = 1'b1;
        waddr      = hit_idx;
        wdata      = rdata;
        cnt_next   = cnt - CW'(1);
        res_load   = 1'b1;
        res_status = ST_OK;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      value_q  <= cur_value;
      prod_q   <= PW'(cur.random_word) * PW'(cnt);
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + AW'(1);
      if (scan_hit) begin
        hit_idx <= scan_idx;
      end
    end
    if (res_load) begin
      res.item   <= res_item;
      res.status <= res_status;
      res.count  <= COUNT_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.data  = res;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid)
    else $error("result overwritten before taken");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(scan_idx) < cnt))
    else $error("search ran past fill count");
  a_move_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("delete did not shrink count");
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst) cnt <= CAP_CNT)
    else $error("fill count beyond capacity");

endmodule

`default_nettype wire

// ===== hdl/unordered_set_table_unit.sv =====
// Channel  Dir  Payload fields                         Handshake
// req      in   kind, value, slot, random_word          valid/ready
// rsp      out  item, status, count                     valid/ready
//
// Steps: add, insert, unknown kinds and any request that misses at once answer
//   from idle; a get hit reads its slot, a choose hit first scales the random word
//   to a slot and then reads it; delete scans from slot 0 (one slot read per cycle)
//   and moves the last member into the hole, or scans all count slots on a miss.
// Reset: a clearing pass writes zero to every slot, with req.ready held low until it ends.
// Stalls: a two-entry queue takes requests while a result waits on rsp.
`default_nettype none

module unordered_set_table_unit import ust_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ust_stream_if.sink   req,
  ust_stream_if.source rsp
);

  // decoded requests between the front (accept, classify, queue)
  // and the back (sequencer over the slot memory)
  ust_stream_if #(.T(cmd_t)) cmd_ch ();

  logic clear_busy;

  ust_front #(.CAPACITY(CAPACITY)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd        (cmd_ch),
    .clear_busy (clear_busy)
  );

  // back end owns the fill count, the slot memory and the result register
  ust_back #(.CAPACITY(CAPACITY), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp),
    .clear_busy (clear_busy)
  );

endmodule

`default_nettype wire

// ===== tb/unordered_set_table_unit_test.sv =====
module unordered_set_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ust_pkg::*;

  localparam int SET_CAPACITY = DEF_CAPACITY;
  localparam int SET_AW = $clog2(SET_CAPACITY);
  localparam int RANDOM_REQUESTS = 1525;
  // longest back-end walk is a delete missing over a full table, plus queue slack
  localparam int DRAIN_CYCLES = SET_CAPACITY + 16;
  localparam int HOLD_AT = 400;       // requests accepted before the long rsp hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM = 600;     // stretch with no random idling on either side
  localparam int CALM_TO = 900;
  localparam int REPORT_LIMIT = 10;

  logic clk;
  logic rst;

  ust_stream_if #(.T(req_t)) req_ch ();
  ust_stream_if #(.T(rsp_t)) rsp_ch ();

  unordered_set_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow of the set: members live in slots 0 .. set_count-1, stale words above.
  logic [VALUE_W-1:0] set_slots [SET_CAPACITY];
  int unsigned        set_count;

  req_t pending_requests [$];   // built by the stimulus block, drained by the driver
  rsp_t awaited_results [$];    // one per accepted request, oldest first

  int unsigned items_made;
  int unsigned req_accepted;
  int unsigned rsp_checked;
  int unsigned fail_count;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned status_seen [3];
  int unsigned kind_seen [6];
  int unsigned peak_fill;
  logic        calm;

  assign calm = (req_accepted >= CALM_FROM) && (req_accepted < CALM_TO);

  // Clock; every block input gets a known value before the first edge.
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Predictor: applies one request to the shadow set and returns its result.
  function automatic rsp_t table_result(input req_t r);
    rsp_t        res;
    int unsigned i;
    bit          found;
    res = '0;
    res.status = ST_OK;
    found = 1'b0;
    case (r.kind)
      KIND_ADD: begin
        if (set_count >= SET_CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          set_slots[SET_AW'(set_count)] = r.value;
          set_count++;
        end
      end
      KIND_DELETE: begin
        // first match from slot 0; last member backfills the hole
        res.status = ST_MISS;
        for (i = 0; i < set_count && !found; i++) begin
          if (set_slots[SET_AW'(i)] == r.value) begin
            found = 1'b1;
            set_count--;
            set_slots[SET_AW'(i)] = set_slots[SET_AW'(set_count)];
            res.status = ST_OK;
          end
        end
      end
      KIND_GET: begin
        if (r.slot >= set_count) res.status = ST_MISS;
        else res.item = set_slots[r.slot];
      end
      KIND_CHOOSE: begin
        if (set_count == 0) res.status = ST_MISS;
        else res.item = set_slots[SET_AW'((32'(r.random_word) * set_count) >> 16)];
      end
      KIND_INSERT: begin
        // 6-bit slot can never reach past a 64-entry table
        set_slots[r.slot] = r.value;
        if (r.slot >= set_count) set_count = r.slot + 1;
      end
      default: begin
        res.status = ST_MISS;
      end
    endcase
    res.count = COUNT_W'(set_count);
    return res;
  endfunction

  // Driver: presents the next pending request once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        req_ch.data <= pending_requests.pop_front();
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure plus one long hold-off so the
  // request queue fills and req.ready drops.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!hold_done && req_accepted >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // Monitor: check the result taken this edge first, then predict the request
  // taken this edge, so the queue order never depends on process order.
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("Error: result with nothing outstanding: item %h status %0d count %0d",
                     got.item, got.status, got.count);
        end else begin
          want = awaited_results.pop_front();
          if (got.item !== want.item || got.status !== want.status ||
              got.count !== want.count) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("Error: result %0d expected item %h status %0d count %0d",
                       rsp_checked, want.item, want.status, want.count);
              $display("       got item %h status %0d count %0d",
                       got.item, got.status, got.count);
            end
          end
          rsp_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = table_result(req_ch.data);
        awaited_results.push_back(want);
        req_accepted++;
        status_seen[want.status]++;
        kind_seen[(req_ch.data.kind > KIND_INSERT) ? 3'd5 : req_ch.data.kind]++;
        if (set_count > peak_fill) peak_fill = set_count;
      end
    end
  end

  // Keeps only a few requests queued so random picks can track the live set.
  task automatic queue_request(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                               input logic [SLOT_W-1:0] s, input logic [RND_W-1:0] w);
    req_t r;
    while (pending_requests.size() >= 4) @(posedge clk);
    r.kind = k;
    r.value = v;
    r.slot = s;
    r.random_word = w;
    pending_requests.push_back(r);
    items_made++;
  endtask

  // Element words skewed toward edges and small values (duplicates).
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return VALUE_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    int unsigned n;
    int unsigned fill;
    int unsigned roll;
    bit growing;
    logic [KIND_W-1:0] k;
    logic [VALUE_W-1:0] v;
    logic [SLOT_W-1:0] s;
    logic [RND_W-1:0] w;

    for (n = 0; n < SET_CAPACITY; n++) set_slots[SET_AW'(n)] = '0;
    set_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty table misses
    queue_request(KIND_GET, '0, 6'd0, '0);
    queue_request(KIND_CHOOSE, '0, '0, 16'hFFFF);
    queue_request(KIND_DELETE, 32'd5, '0, '0);
    // a few members, 7 twice so delete must take the first one
    queue_request(KIND_ADD, 32'd7, '0, '0);
    queue_request(KIND_ADD, 32'hFFFF_FFFF, '1, '1);
    queue_request(KIND_ADD, 32'h0, '0, '0);
    queue_request(KIND_ADD, 32'd7, '0, '0);
    queue_request(KIND_ADD, 32'h1234_5678, '0, '0);
    queue_request(KIND_DELETE, 32'd7, '0, '0);        // slot 0 hit, last member moves in
    queue_request(KIND_GET, '0, 6'd0, '0);
    queue_request(KIND_GET, '0, 6'd3, '0);
    queue_request(KIND_GET, '0, 6'd4, '0);            // at the count
    queue_request(KIND_CHOOSE, '0, '0, 16'h0000);
    queue_request(KIND_CHOOSE, '0, '0, 16'hFFFF);
    queue_request(KIND_DELETE, 32'hDEAD_BEEF, '0, '0); // absent
    queue_request(KIND_DELETE, 32'd7, '0, '0);        // last slot, leaves a stale 7
    queue_request(KIND_INSERT, 32'hA5A5_A5A5, 6'd6, '0); // past the count
    queue_request(KIND_GET, '0, 6'd3, '0);            // stale word revived
    queue_request(KIND_GET, '0, 6'd5, '0);            // never written, still zero
    queue_request(KIND_INSERT, 32'h5A5A_5A5A, 6'd63, '0); // fills the table
    queue_request(KIND_ADD, 32'h1, '0, '0);           // full
    queue_request(KIND_GET, '0, 6'd63, '0);
    queue_request(3'd5, '1, '1, '1);                  // undefined kinds
    queue_request(3'd6, '0, '0, '0);
    queue_request(3'd7, 32'hFFFF_0000, 6'd42, 16'h5555);

    // --- random: alternate shrinking and growing spells so the fill level
    // sweeps the whole table; deletes mostly name a live member
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      growing = ((n / 150) % 2) == 1;
      fill = set_count;
      roll = $urandom_range(0, 99);
      v = pick_word();
      s = SLOT_W'($urandom);
      w = RND_W'($urandom);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      if (roll < (growing ? 45 : 15)) begin
        k = KIND_ADD;
      end else if (roll < 60) begin
        k = KIND_DELETE;
        if (fill > 0 && $urandom_range(0, 4) != 0)
          v = set_slots[SET_AW'($urandom_range(0, fill - 1))];
      end else if (roll < 75) begin
        k = KIND_GET;
        if ($urandom_range(0, 4) != 0) s = (fill > 63) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, fill));
      end else if (roll < 85) begin
        k = KIND_CHOOSE;
      end else if (roll < 95) begin
        k = KIND_INSERT;
        if ($urandom_range(0, 3) != 0) s = (fill > 63) ? 6'($urandom_range(0, 63))
                                                       : 6'($urandom_range(0, fill));
      end else begin
        k = 3'($urandom_range(5, 7));
      end
      queue_request(k, v, s, w);
    end

    // --- drain
    while (req_accepted < items_made) @(posedge clk);
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d miss, %0d full; peak fill %0d of %0d",
             rsp_checked, status_seen[0], status_seen[1], status_seen[2],
             peak_fill, SET_CAPACITY);
    $display("Requests add/delete/get/choose/insert/undefined: %0d/%0d/%0d/%0d/%0d/%0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
